[sv/abdv_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// abdv_pkg
// Shared types and constants of the arcade bus decoder and video RAM core.
// ---------------------------------------------------------------------------
package abdv_pkg;

  // Item kinds carried on the input tuser field
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FETCH = 2'd2,
    ACT_LINE  = 2'd3
  } action_t;

  // Decoded bus regions
  typedef enum logic [3:0] {
    RGN_ROM,
    RGN_WORK,
    RGN_VIDEO,
    RGN_ATTR,
    RGN_OBJ,
    RGN_PORT0,
    RGN_PORT1,
    RGN_CTRL,
    RGN_OPEN
  } region_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_DIP_A = 2'd0;
  localparam logic [1:0] CFG_DIP_B = 2'd1;
  localparam logic [1:0] CFG_DIP_C = 2'd2;

  // Control register selects within 0x7000-0x77FF
  localparam logic [2:0] CTRL_NMI   = 3'd1;
  localparam logic [2:0] CTRL_STARS = 3'd4;

  // Line on which NMI fires
  localparam logic [8:0] NMI_LINE = 9'd248;

  // Read value of an unmapped address
  localparam logic [7:0] OPEN_BUS = 8'hFF;

  // Payload widths
  localparam int IN_W  = 56;
  localparam int OUT_W = 40;

  // Classified item as it sits in the queue
  typedef struct packed {
    action_t     action;
    region_t     region;
    logic [9:0]  addr;
    logic [7:0]  wdata;
    logic [4:0]  port0;
    logic [1:0]  port1;
    logic [9:0]  tile;
    logic        line_match;
  } item_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

endpackage
`default_nettype wire

[sv/abdv_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// abdv_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module abdv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/abdv_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// abdv_front
// Accepts input transactions, decodes the bus region and holds them in a
// two-entry queue for the back end.
// ---------------------------------------------------------------------------
module abdv_front (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire [abdv_pkg::IN_W-1:0]    s_tdata,
  input  wire [1:0]                   s_tuser,
  input  wire                         clearing,
  output logic                        head_valid,
  output abdv_pkg::item_t             head,
  input  wire                         pop
);
  import abdv_pkg::*;

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  item_t       incoming;
  logic [15:0] bus_addr;

  // Decode the CPU address into a region
  function automatic region_t decode(input logic [15:0] a);
    region_t r;
    if (a[15:14] == 2'b00) begin
      r = RGN_ROM;
    end else begin
      unique case (a[15:11])
        5'b01000: r = RGN_WORK;
        5'b01010: r = RGN_VIDEO;
        5'b01011: r = (a[7:6] == 2'b00) ? RGN_ATTR : RGN_OBJ;
        5'b01100: r = RGN_PORT0;
        5'b01101: r = RGN_PORT1;
        5'b01110: r = RGN_CTRL;
        default:  r = RGN_OPEN;
      endcase
    end
    return r;
  endfunction

  // Unpack and classify the incoming transaction
  always_comb begin
    bus_addr            = s_tdata[15:0];
    incoming.action     = action_t'(s_tuser);
    incoming.region     = decode(bus_addr);
    incoming.addr       = bus_addr[9:0];
    incoming.wdata      = s_tdata[23:16];
    incoming.port0      = s_tdata[28:24];
    incoming.port1      = s_tdata[30:29];
    incoming.tile       = s_tdata[40:31];
    incoming.line_match = (s_tdata[49:41] == NMI_LINE);
  end

  assign s_tready   = (count != 2'd2) && !clearing;
  assign push       = s_tvalid && s_tready;
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/abdv_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// abdv_back
// Executes queued items against the board RAMs: issues the reads on pop,
// then writes back and registers the result once the output is free.
// ---------------------------------------------------------------------------
module abdv_back (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  wire [1:0]                   cfg_index,
  input  wire [7:0]                   cfg_data,
  input  wire                         head_valid,
  input  wire abdv_pkg::item_t        head,
  output logic                        pop,
  output logic                        clearing,
  output logic                        m_tvalid,
  input  wire                         m_tready,
  output logic [abdv_pkg::OUT_W-1:0]  m_tdata
);
  import abdv_pkg::*;

  bk_state_t   state, state_next;
  logic [9:0]  clr_cnt;
  item_t       cur;
  item_t       src;
  logic        go;

  logic [7:0]  dip_a, dip_b, dip_c;
  logic        nmi_latch, stars_latch;
  logic        nmi_latch_next, stars_latch_next;

  // RAM ports
  logic        work_we, video_we, even_we, odd_we, obj_we, dirty_we;
  logic [9:0]  work_addr, video_addr;
  logic [4:0]  attr_addr, dirty_addr;
  logic [7:0]  obj_addr;
  logic [9:0]  work_waddr, video_waddr;
  logic [4:0]  attr_waddr, dirty_waddr;
  logic [7:0]  obj_waddr;
  logic [7:0]  byte_wdata;
  logic [31:0] dirty_wdata;
  logic [7:0]  work_rd, video_rd, even_rd, odd_rd, obj_rd;
  logic [31:0] dirty_rd;

  // Execute-stage signals
  logic        is_write;
  logic [31:0] col_bit_video, col_bit_tile;
  logic [7:0]  attr_old;
  logic [7:0]  read_data;
  logic        rom_hit;
  logic [8:0]  scroll;
  logic [OUT_W-1:0] result;

  assign clearing = (state == BK_CLEAR);
  assign pop      = (state == BK_IDLE) && head_valid;
  assign go       = (state == BK_EXEC) && (!m_tvalid || m_tready);

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: if (clr_cnt == 10'h3FF) state_next = BK_IDLE;
      BK_IDLE:  if (head_valid) state_next = BK_EXEC;
      BK_EXEC:  if (go) state_next = BK_IDLE;
      default:  state_next = BK_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_CLEAR;
      clr_cnt <= 10'd0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_cnt <= clr_cnt + 10'd1;
      end
    end
  end

  // Hold the item under execution
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dip_a <= 8'd0;
      dip_b <= 8'd0;
      dip_c <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIP_A: dip_a <= cfg_data;
        CFG_DIP_B: dip_b <= cfg_data;
        CFG_DIP_C: dip_c <= cfg_data;
        default:   dip_a <= dip_a;
      endcase
    end
  end

  // Read addresses follow the queue head on issue, the held item after
  assign src        = (state == BK_EXEC) ? cur : head;
  assign work_addr  = src.addr;
  assign video_addr = (src.action == ACT_FETCH) ? src.tile : src.addr;
  assign attr_addr  = (src.action == ACT_FETCH) ? src.tile[4:0] : src.addr[5:1];
  assign obj_addr   = src.addr[7:0];
  always_comb begin
    if (src.action == ACT_FETCH) begin
      dirty_addr = src.tile[4:0];
    end else if (src.region == RGN_ATTR) begin
      dirty_addr = src.addr[5:1];
    end else begin
      dirty_addr = src.addr[4:0];
    end
  end

  // Write-back decisions
  assign is_write      = (cur.action == ACT_WRITE);
  assign col_bit_video = 32'd1 << cur.addr[9:5];
  assign col_bit_tile  = 32'd1 << cur.tile[9:5];
  assign attr_old      = cur.addr[0] ? odd_rd : even_rd;

  always_comb begin
    work_we     = 1'b0;
    video_we    = 1'b0;
    even_we     = 1'b0;
    odd_we      = 1'b0;
    obj_we      = 1'b0;
    dirty_we    = 1'b0;
    work_waddr  = work_addr;
    video_waddr = video_addr;
    attr_waddr  = attr_addr;
    obj_waddr   = obj_addr;
    dirty_waddr = dirty_addr;
    byte_wdata  = cur.wdata;
    dirty_wdata = dirty_rd;
    if (state == BK_CLEAR) begin
      // Sweep every RAM: data to zero, dirty marks to all set
      work_we     = 1'b1;
      video_we    = 1'b1;
      even_we     = 1'b1;
      odd_we      = 1'b1;
      obj_we      = 1'b1;
      dirty_we    = 1'b1;
      work_waddr  = clr_cnt;
      video_waddr = clr_cnt;
      attr_waddr  = clr_cnt[4:0];
      obj_waddr   = clr_cnt[7:0];
      dirty_waddr = clr_cnt[4:0];
      byte_wdata  = 8'd0;
      dirty_wdata = '1;
    end else if (go) begin
      if (is_write) begin
        case (cur.region)
          RGN_WORK: work_we = 1'b1;
          RGN_VIDEO: begin
            if (video_rd != cur.wdata) begin
              video_we    = 1'b1;
              dirty_we    = 1'b1;
              dirty_wdata = dirty_rd | col_bit_video;
            end
          end
          RGN_ATTR: begin
            if (attr_old != cur.wdata) begin
              even_we     = !cur.addr[0];
              odd_we      = cur.addr[0];
              dirty_we    = 1'b1;
              dirty_wdata = '1;
            end
          end
          RGN_OBJ: obj_we = 1'b1;
          default: obj_we = 1'b0;
        endcase
      end else if (cur.action == ACT_FETCH) begin
        // Clear the mark of the fetched tile
        dirty_we    = 1'b1;
        dirty_wdata = dirty_rd & ~col_bit_tile;
      end
    end
  end

  // Control latches after the action
  always_comb begin
    nmi_latch_next   = nmi_latch;
    stars_latch_next = stars_latch;
    if (is_write && cur.region == RGN_CTRL) begin
      if (cur.addr[2:0] == CTRL_NMI) begin
        nmi_latch_next = cur.wdata[0];
      end else if (cur.addr[2:0] == CTRL_STARS) begin
        stars_latch_next = cur.wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nmi_latch   <= 1'b0;
      stars_latch <= 1'b0;
    end else if (go) begin
      nmi_latch   <= nmi_latch_next;
      stars_latch <= stars_latch_next;
    end
  end

  // Bus read data
  always_comb begin
    rom_hit = 1'b0;
    unique case (cur.region)
      RGN_ROM: begin
        read_data = 8'd0;
        rom_hit   = 1'b1;
      end
      RGN_WORK:  read_data = work_rd;
      RGN_VIDEO: read_data = video_rd;
      RGN_ATTR:  read_data = attr_old;
      RGN_OBJ:   read_data = obj_rd;
      RGN_PORT0: read_data = {3'd0, cur.port0} | dip_a;
      RGN_PORT1: read_data = {6'd0, cur.port1} | dip_b;
      RGN_CTRL:  read_data = dip_c;
      default:   read_data = OPEN_BUS;
    endcase
  end

  // Reversed column times eight plus row scroll
  assign scroll = {1'b0, ~cur.tile[9:5], 3'b000} + {1'b0, even_rd};

  // Pack the result, lowest field first
  always_comb begin
    result = '0;
    unique case (cur.action)
      ACT_READ: begin
        result[7:0] = read_data;
        result[8]   = rom_hit;
      end
      ACT_FETCH: begin
        result[16:9]  = video_rd;
        result[21:17] = {odd_rd[2:0], 2'b00};
        result[30:22] = scroll;
        result[31]    = |(dirty_rd & col_bit_tile);
      end
      ACT_LINE:  result[32] = cur.line_match && nmi_latch;
      default:   result[32] = 1'b0;
    endcase
    result[33] = nmi_latch_next;
    result[34] = stars_latch_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata <= result;
    end
  end

  // Board RAMs
  abdv_ram #(.WIDTH(8), .DEPTH(1024)) u_work (
    .clk(clk), .we(work_we), .waddr(work_waddr), .wdata(byte_wdata),
    .re(pop), .raddr(work_addr), .rdata(work_rd)
  );

  abdv_ram #(.WIDTH(8), .DEPTH(1024)) u_video (
    .clk(clk), .we(video_we), .waddr(video_waddr), .wdata(byte_wdata),
    .re(pop), .raddr(video_addr), .rdata(video_rd)
  );

  abdv_ram #(.WIDTH(8), .DEPTH(32)) u_attr_even (
    .clk(clk), .we(even_we), .waddr(attr_waddr), .wdata(byte_wdata),
    .re(pop), .raddr(attr_addr), .rdata(even_rd)
  );

  abdv_ram #(.WIDTH(8), .DEPTH(32)) u_attr_odd (
    .clk(clk), .we(odd_we), .waddr(attr_waddr), .wdata(byte_wdata),
    .re(pop), .raddr(attr_addr), .rdata(odd_rd)
  );

  // Sprite, bullet and scratch RAM share one store indexed by the low byte
  abdv_ram #(.WIDTH(8), .DEPTH(256)) u_obj (
    .clk(clk), .we(obj_we), .waddr(obj_waddr), .wdata(byte_wdata),
    .re(pop), .raddr(obj_addr), .rdata(obj_rd)
  );

  // Dirty marks: one word per row, one bit per column
  abdv_ram #(.WIDTH(32), .DEPTH(32)) u_dirty (
    .clk(clk), .we(dirty_we), .waddr(dirty_waddr), .wdata(dirty_wdata),
    .re(pop), .raddr(dirty_addr), .rdata(dirty_rd)
  );

endmodule
`default_nettype wire

[sv/arcade_bus_decoder_video_ram_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// arcade_bus_decoder_video_ram_core
// CPU memory map of an arcade board with video RAM dirty tracking.
// ---------------------------------------------------------------------------
// Each input transaction is a bus read, bus write, tile fetch or scanline
// event and yields exactly one result transaction. The execute stage
// issues the RAM reads, then, once the output register is free, writes
// back and registers the result; only then does it take the next item.
// A two-entry queue in front keeps accepting while a result waits. After
// reset the core sweeps all RAMs (zeroing data, setting every dirty mark)
// and holds s_tready low meanwhile; DIP writes are taken at any time.
module arcade_bus_decoder_video_ram_core (
  input  wire                         clk,
  input  wire                         rst,
  // Input stream
  input  wire                         s_tvalid,
  output logic                        s_tready,
  // bus_address[15:0], write_data[23:16], port0_buttons[28:24],
  // port1_buttons[30:29], tile_index[40:31], scanline[49:41], zero fill
  input  wire [abdv_pkg::IN_W-1:0]    s_tdata,
  // action[1:0]
  input  wire [1:0]                   s_tuser,
  // Result stream
  output logic                        m_tvalid,
  input  wire                         m_tready,
  // read_data[7:0], rom_hit[8], tile_code[16:9], tile_color[21:17],
  // tile_scroll[30:22], tile_dirty[31], nmi_line[32], nmi_enabled[33],
  // stars_enabled[34], zero fill
  output logic [abdv_pkg::OUT_W-1:0]  m_tdata,
  // Configuration write port
  input  wire                         cfg_we,
  input  wire [1:0]                   cfg_index,
  input  wire [7:0]                   cfg_data
);
  import abdv_pkg::*;

  item_t head;
  logic  head_valid;
  logic  pop;
  logic  clearing;

  // Accept and classify
  abdv_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser),
    .clearing(clearing),
    .head_valid(head_valid), .head(head), .pop(pop)
  );

  // Execute against the RAMs
  abdv_back u_back (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .head_valid(head_valid), .head(head), .pop(pop),
    .clearing(clearing),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule
`default_nettype wire

[test/abdv_bus_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abdv_bus_checker
// Scoreboard for the arcade bus decoder and video RAM core.
// ---------------------------------------------------------------------------
// Watches the input, result and configuration ports. It keeps its own copy
// of the memory map: RAM contents, per-tile dirty marks, control latches and
// DIP banks. For every accepted input transaction it predicts one result.
// Each accepted result transaction is compared, field by field, with the
// oldest prediction. Counts of mismatches and pending predictions go back
// to the testbench top.
// ---------------------------------------------------------------------------
module abdv_bus_checker (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  input  wire                         s_tready,
  // bus_address[15:0], write_data[23:16], port0_buttons[28:24],
  // port1_buttons[30:29], tile_index[40:31], scanline[49:41], zero fill
  input  wire [abdv_pkg::IN_W-1:0]    s_tdata,
  // action[1:0]
  input  wire [1:0]                   s_tuser,
  input  wire                         m_tvalid,
  input  wire                         m_tready,
  // read_data[7:0], rom_hit[8], tile_code[16:9], tile_color[21:17],
  // tile_scroll[30:22], tile_dirty[31], nmi_line[32], nmi_enabled[33],
  // stars_enabled[34], zero fill
  input  wire [abdv_pkg::OUT_W-1:0]   m_tdata,
  input  wire                         cfg_we,
  input  wire [1:0]                   cfg_index,
  input  wire [7:0]                   cfg_data,
  output int                          mismatch_count,
  output int                          outstanding,
  output int                          results_checked,
  output int                          dirty_fetches,
  output int                          nmi_pulses
);
  import abdv_pkg::*;

  // Address map boundaries
  localparam logic [15:0] ROM_LAST    = 16'h3FFF;
  localparam logic [15:0] WORK_FIRST  = 16'h4000;
  localparam logic [15:0] WORK_LAST   = 16'h47FF;
  localparam logic [15:0] VIDEO_FIRST = 16'h5000;
  localparam logic [15:0] VIDEO_LAST  = 16'h57FF;
  localparam logic [15:0] OBJ_FIRST   = 16'h5800;
  localparam logic [15:0] OBJ_LAST    = 16'h5FFF;
  localparam logic [15:0] PORT0_FIRST = 16'h6000;
  localparam logic [15:0] PORT0_LAST  = 16'h67FF;
  localparam logic [15:0] PORT1_FIRST = 16'h6800;
  localparam logic [15:0] PORT1_LAST  = 16'h6FFF;
  localparam logic [15:0] CTRL_FIRST  = 16'h7000;
  localparam logic [15:0] CTRL_LAST   = 16'h77FF;

  // Low-byte split of the object area
  localparam logic [7:0] ATTR_LAST   = 8'h3F;
  localparam logic [7:0] SPRITE_LAST = 8'h5F;
  localparam logic [7:0] BULLET_LAST = 8'h7F;

  // Cap on printed mismatch lines; every mismatch is still counted
  localparam int MAX_REPORTS = 200;

  // Packed from the top bit down, so read_data lands in the lowest bits
  typedef struct packed {
    logic       stars_enabled;
    logic       nmi_enabled;
    logic       nmi_line;
    logic       tile_dirty;
    logic [8:0] tile_scroll;
    logic [4:0] tile_color;
    logic [7:0] tile_code;
    logic       rom_hit;
    logic [7:0] read_data;
  } bus_response_t;

  logic [7:0]  dip_a, dip_b, dip_c;
  logic [7:0]  work_mem    [1024];
  logic [7:0]  video_mem   [1024];
  logic [7:0]  attr_mem    [64];
  logic [7:0]  sprite_mem  [32];
  logic [7:0]  bullet_mem  [32];
  logic [7:0]  scratch_mem [128];
  // Word = tile row, bit = tile column
  logic [31:0] dirty_rows  [32];
  logic        nmi_en, stars_en;

  bus_response_t expected_responses [$];
  bus_response_t got_resp, want_resp;

  // Count each mismatch and print a line for the first MAX_REPORTS
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("ERROR: %s", msg);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                results_checked, name, got, want));
    end
  endtask

  // Return the model to its post-reset state
  task automatic clear_model();
    int i;
    for (i = 0; i < 1024; i++) begin
      work_mem[i]  = 8'h00;
      video_mem[i] = 8'h00;
    end
    for (i = 0; i < 128; i++) scratch_mem[i] = 8'h00;
    for (i = 0; i < 64; i++) attr_mem[i] = 8'h00;
    for (i = 0; i < 32; i++) begin
      sprite_mem[i] = 8'h00;
      bullet_mem[i] = 8'h00;
      dirty_rows[i] = '1;
    end
    dip_a    = 8'h00;
    dip_b    = 8'h00;
    dip_c    = 8'h00;
    nmi_en   = 1'b0;
    stars_en = 1'b0;
    expected_responses.delete();
  endtask

  // Apply one bus action to the model and work out its result
  task automatic compute_bus_response(input action_t act,
                                      input logic [IN_W-1:0] payload,
                                      output bus_response_t r);
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [4:0]  p0;
    logic [1:0]  p1;
    logic [9:0]  tile;
    logic [8:0]  line;
    logic [7:0]  off;
    logic [4:0]  col;
    logic [4:0]  row;
    addr  = payload[15:0];
    wdata = payload[23:16];
    p0    = payload[28:24];
    p1    = payload[30:29];
    tile  = payload[40:31];
    line  = payload[49:41];
    off   = addr[7:0];
    r     = '0;
    case (act)
      ACT_READ: begin
        if (addr <= ROM_LAST) begin
          r.rom_hit = 1'b1;
        end else if (addr >= WORK_FIRST && addr <= WORK_LAST) begin
          r.read_data = work_mem[addr[9:0]];
        end else if (addr >= VIDEO_FIRST && addr <= VIDEO_LAST) begin
          r.read_data = video_mem[addr[9:0]];
        end else if (addr >= OBJ_FIRST && addr <= OBJ_LAST) begin
          if (off <= ATTR_LAST) r.read_data = attr_mem[off[5:0]];
          else if (off <= SPRITE_LAST) r.read_data = sprite_mem[off[4:0]];
          else if (off <= BULLET_LAST) r.read_data = bullet_mem[off[4:0]];
          else r.read_data = scratch_mem[off[6:0]];
        end else if (addr >= PORT0_FIRST && addr <= PORT0_LAST) begin
          r.read_data = {3'b000, p0} | dip_a;
        end else if (addr >= PORT1_FIRST && addr <= PORT1_LAST) begin
          r.read_data = {6'b000000, p1} | dip_b;
        end else if (addr >= CTRL_FIRST && addr <= CTRL_LAST) begin
          r.read_data = dip_c;
        end else begin
          r.read_data = OPEN_BUS;
        end
      end
      ACT_WRITE: begin
        if (addr >= WORK_FIRST && addr <= WORK_LAST) begin
          work_mem[addr[9:0]] = wdata;
        end else if (addr >= VIDEO_FIRST && addr <= VIDEO_LAST) begin
          // Mark the tile only when its byte really changes
          if (video_mem[addr[9:0]] != wdata) begin
            video_mem[addr[9:0]] = wdata;
            dirty_rows[addr[4:0]][addr[9:5]] = 1'b1;
          end
        end else if (addr >= OBJ_FIRST && addr <= OBJ_LAST) begin
          if (off <= ATTR_LAST) begin
            // A changed attribute byte marks every tile of its row word
            if (attr_mem[off[5:0]] != wdata) begin
              attr_mem[off[5:0]] = wdata;
              dirty_rows[off[5:1]] = '1;
            end
          end else if (off <= SPRITE_LAST) begin
            sprite_mem[off[4:0]] = wdata;
          end else if (off <= BULLET_LAST) begin
            bullet_mem[off[4:0]] = wdata;
          end else begin
            scratch_mem[off[6:0]] = wdata;
          end
        end else if (addr >= CTRL_FIRST && addr <= CTRL_LAST) begin
          if (addr[2:0] == CTRL_NMI) nmi_en = wdata[0];
          else if (addr[2:0] == CTRL_STARS) stars_en = wdata[0];
        end
      end
      ACT_FETCH: begin
        col           = tile[9:5];
        row           = tile[4:0];
        r.tile_code   = video_mem[tile];
        r.tile_color  = {attr_mem[{row, 1'b1}][2:0], 2'b00};
        r.tile_scroll = {1'b0, 5'd31 - col, 3'b000} + {1'b0, attr_mem[{row, 1'b0}]};
        r.tile_dirty  = dirty_rows[row][col];
        dirty_rows[row][col] = 1'b0;
      end
      default: begin
        r.nmi_line = (line == NMI_LINE) && nmi_en;
      end
    endcase
    r.nmi_enabled   = nmi_en;
    r.stars_enabled = stars_en;
  endtask

  // Sample all channels on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      mismatch_count  = 0;
      results_checked = 0;
      dirty_fetches   = 0;
      nmi_pulses      = 0;
    end else begin
      // Check the result first: it always belongs to an earlier input
      if (m_tvalid && m_tready) begin
        got_resp = bus_response_t'(m_tdata[34:0]);
        if (expected_responses.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no prediction waiting",
                                    results_checked));
        end else begin
          want_resp = expected_responses.pop_front();
          check_field("read_data", 16'(got_resp.read_data), 16'(want_resp.read_data));
          check_field("rom_hit", 16'(got_resp.rom_hit), 16'(want_resp.rom_hit));
          check_field("tile_code", 16'(got_resp.tile_code), 16'(want_resp.tile_code));
          check_field("tile_color", 16'(got_resp.tile_color),
                      16'(want_resp.tile_color));
          check_field("tile_scroll", 16'(got_resp.tile_scroll),
                      16'(want_resp.tile_scroll));
          check_field("tile_dirty", 16'(got_resp.tile_dirty),
                      16'(want_resp.tile_dirty));
          check_field("nmi_line", 16'(got_resp.nmi_line), 16'(want_resp.nmi_line));
          check_field("nmi_enabled", 16'(got_resp.nmi_enabled),
                      16'(want_resp.nmi_enabled));
          check_field("stars_enabled", 16'(got_resp.stars_enabled),
                      16'(want_resp.stars_enabled));
          if (want_resp.tile_dirty) dirty_fetches++;
          if (want_resp.nmi_line) nmi_pulses++;
        end
        results_checked++;
      end
      // Predict the result of an accepted input transaction
      if (s_tvalid && s_tready) begin
        compute_bus_response(action_t'(s_tuser), s_tdata, want_resp);
        expected_responses = {expected_responses, want_resp};
      end
      // Track DIP bank writes; spare indexes are ignored
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIP_A: dip_a = cfg_data;
          CFG_DIP_B: dip_b = cfg_data;
          CFG_DIP_C: dip_c = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = expected_responses.size();
  end

endmodule

[test/tb_arcade_bus_decoder_video_ram_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_arcade_bus_decoder_video_ram_core
// Testbench for the arcade bus decoder and video RAM core.
// ---------------------------------------------------------------------------
// Drives bus reads, bus writes, tile fetches and scanline events into the
// core. A short directed sequence covers the map edges, mirrors, dirty mark
// rules and the NMI and star latches. Random traffic follows in three phases
// with different source and sink throttling and DIP bank settings. A checker
// beside the core predicts and compares every result; this module makes the
// stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module tb_arcade_bus_decoder_video_ram_core;
  import abdv_pkg::*;

  localparam int         PHASE_ITEMS    = 620;
  localparam int         RESET_CYCLES   = 12;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         WATCHDOG_LIMIT = 5000;
  // Index beyond the DIP banks; writes to it must have no effect
  localparam logic [1:0] CFG_SPARE      = 2'd3;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic [1:0]        s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [7:0]        cfg_data;

  int mismatch_count;
  int outstanding;
  int results_checked;
  int dirty_fetches;
  int nmi_pulses;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int quiet_cycles  = 0;

  arcade_bus_decoder_video_ram_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  abdv_bus_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .dirty_fetches   (dirty_fetches),
    .nmi_pulses      (nmi_pulses)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Throttle the result side at the falling edge
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one input transaction; entered and left just after a falling edge
  task automatic send_transaction(input action_t act, input logic [IN_W-1:0] payload);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= payload;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_item(input action_t act, input logic [15:0] addr,
                           input logic [7:0] wdata, input logic [4:0] p0,
                           input logic [1:0] p1, input logic [9:0] tile,
                           input logic [8:0] line);
    send_transaction(act, {6'b000000, line, tile, p1, p0, wdata, addr});
  endtask

  // Directed helpers; fields the action ignores get random values
  task automatic do_read(input logic [15:0] addr, input logic [4:0] p0,
                         input logic [1:0] p1);
    send_item(ACT_READ, addr, 8'($urandom), p0, p1, 10'($urandom), 9'($urandom));
  endtask

  task automatic do_write(input logic [15:0] addr, input logic [7:0] wdata);
    send_item(ACT_WRITE, addr, wdata, 5'($urandom), 2'($urandom), 10'($urandom),
              9'($urandom));
  endtask

  task automatic do_fetch(input logic [9:0] tile);
    send_item(ACT_FETCH, 16'($urandom), 8'($urandom), 5'($urandom), 2'($urandom),
              tile, 9'($urandom));
  endtask

  task automatic do_line(input logic [8:0] line);
    send_item(ACT_LINE, 16'($urandom), 8'($urandom), 5'($urandom), 2'($urandom),
              10'($urandom), line);
  endtask

  // Lower valid, wait for every result, then let the core settle
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all DIP banks and poke the spare index
  task automatic set_dips(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIP_A;
    cfg_data  <= a;
    @(negedge clk);
    cfg_index <= CFG_DIP_B;
    cfg_data  <= b;
    @(negedge clk);
    cfg_index <= CFG_DIP_C;
    cfg_data  <= c;
    @(negedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= 8'($urandom);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Pick an address, weighted towards the mapped regions
  function automatic logic [15:0] pick_address();
    int unsigned sel;
    logic [15:0] a;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      a = 16'($urandom_range(0, 16'h3FFF));
    end else if (sel < 20) begin
      a = 16'h4000 + 16'($urandom_range(0, 16'h7FF));
    end else if (sel < 40) begin
      // Video RAM, often in the tiles that fetches favour, either mirror
      a = 16'h5000 | (16'($urandom_range(0, 1)) << 10) |
          ($urandom_range(0, 1) ? 16'($urandom_range(0, 63)) : 16'($urandom_range(0, 1023)));
    end else if (sel < 62) begin
      // Object area, attribute bytes half the time
      a = 16'h5800 | (16'($urandom_range(0, 7)) << 8) |
          ($urandom_range(0, 1) ? 16'($urandom_range(0, 8'h3F)) : 16'($urandom_range(0, 255)));
    end else if (sel < 68) begin
      a = 16'h6000 + 16'($urandom_range(0, 16'h7FF));
    end else if (sel < 74) begin
      a = 16'h6800 + 16'($urandom_range(0, 16'h7FF));
    end else if (sel < 86) begin
      // Control area, hitting the latch selects half the time
      a = 16'h7000 + 16'($urandom_range(0, 16'h7FF));
      if ($urandom_range(0, 1)) a[2:0] = $urandom_range(0, 1) ? CTRL_NMI : CTRL_STARS;
    end else if (sel < 93) begin
      a = $urandom_range(0, 1) ? 16'h4800 + 16'($urandom_range(0, 16'h7FF))
                               : 16'h7800 + 16'($urandom_range(0, 16'h87FF));
    end else begin
      a = 16'($urandom_range(0, 16'hFFFF));
    end
    return a;
  endfunction

  task automatic send_random_item();
    int unsigned pick;
    action_t     act;
    logic [7:0]  wdata;
    logic [9:0]  tile;
    logic [8:0]  line;
    pick = $urandom_range(0, 99);
    if (pick < 35) act = ACT_READ;
    else if (pick < 70) act = ACT_WRITE;
    else if (pick < 88) act = ACT_FETCH;
    else act = ACT_LINE;
    // Small values make unchanged rewrites common
    wdata = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    tile  = $urandom_range(0, 1) ? 10'($urandom_range(0, 63)) : 10'($urandom_range(0, 1023));
    pick  = $urandom_range(0, 9);
    if (pick < 3) line = NMI_LINE;
    else if (pick < 4) line = $urandom_range(0, 1) ? NMI_LINE - 9'd1 : NMI_LINE + 9'd1;
    else line = 9'($urandom_range(0, 511));
    send_item(act, pick_address(), wdata, 5'($urandom_range(0, 31)),
              2'($urandom_range(0, 3)), tile, line);
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct);
    int n;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (n = 0; n < PHASE_ITEMS; n++) send_random_item();
    wait_for_drain();
  endtask

  // Main sequence
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = ACT_READ;
    cfg_we    = 1'b0;
    cfg_index = CFG_DIP_A;
    cfg_data  = 8'h00;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_dips(8'h00, 8'h00, 8'h00);

    // Directed: map edges, mirrors, dirty marks, latches and ports
    src_idle_pct  = 20;
    sink_idle_pct = 48;
    do_read(16'h0000, 5'h00, 2'h0);
    do_read(16'h3FFF, 5'h1F, 2'h3);
    do_read(16'hFFFF, 5'h00, 2'h0);
    do_fetch(10'd0);
    do_fetch(10'd0);
    do_write(16'h5000, 8'h00);
    do_write(16'h5400, 8'hA5);
    do_write(16'h4000, 8'h5A);
    do_read(16'h4400, 5'h00, 2'h0);
    do_write(16'h5801, 8'hFF);
    do_write(16'h5800, 8'hFF);
    do_fetch(10'd0);
    do_fetch(10'd1023);
    do_write(16'h5FFF, 8'h77);
    do_read(16'h58FF, 5'h00, 2'h0);
    do_write(16'h5840, 8'h11);
    do_read(16'h5F40, 5'h00, 2'h0);
    do_write(16'h7001, 8'h01);
    do_write(16'h77FC, 8'hFF);
    do_line(NMI_LINE);
    do_write(16'h7001, 8'h00);
    do_line(NMI_LINE);
    do_read(16'h6000, 5'h1F, 2'h0);
    do_read(16'h6FFF, 5'h00, 2'h3);
    do_read(16'h7000, 5'h00, 2'h0);
    wait_for_drain();

    // Random traffic across DIP settings and throttling profiles
    set_dips(8'hFF, 8'hFF, 8'hFF);
    run_phase(20, 48);
    set_dips(8'($urandom), 8'($urandom), 8'($urandom));
    run_phase(48, 20);
    set_dips(8'($urandom), 8'($urandom), 8'($urandom));
    run_phase(0, 0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d tile fetches found dirty, %0d NMI pulses",
             results_checked, dirty_fetches, nmi_pulses);
    $display("DIP banks at zero, all ones and random; three source/sink throttle profiles");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/abdv_pkg.sv
sv/abdv_ram.sv
sv/abdv_front.sv
sv/abdv_back.sv
sv/arcade_bus_decoder_video_ram_core.sv
test/abdv_bus_checker.sv
test/tb_arcade_bus_decoder_video_ram_core.sv
